// File: hw/rtl/roccb_pkg.sv
// Shared types and constants for the ROC confusion counter bank.
package roccb_pkg;

  localparam int MAX_THRESHOLDS_DEF = 128;
  localparam int COUNT_WIDTH_DEF    = 32;

  localparam int SCORE_W = 16;
  localparam int TRUTH_W = 8;
  localparam int INDEX_W = 7;
  localparam int STEP_W  = 16;
  localparam int CNT_CFG_W = 8;
  localparam int OUT_W   = 32;

  localparam logic [TRUTH_W-1:0] TRUTH_CHANGED   = 8'd255;
  localparam logic [TRUTH_W-1:0] TRUTH_UNCHANGED = 8'd0;

  localparam int STEP_RESET  = 205;
  localparam int COUNT_RESET = 101;

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_STEP  = 1'b0,
    REG_COUNT = 1'b1
  } reg_idx_t;

  // Token handed from cell to cell, one stage per cycle while the row advances.
  typedef struct packed {
    logic                        vld;
    cmd_t                        op;
    logic signed [SCORE_W-1:0]   score;
    logic                        changed;
    logic [STEP_W-1:0]           thr;     // threshold of the cell it enters
    logic                        big;     // threshold beyond 16 bits
    logic [STEP_W-1:0]           step;
    logic [CNT_CFG_W-1:0]        count;
    logic [INDEX_W-1:0]          idx;
    logic [OUT_W-1:0]            tp;
    logic [OUT_W-1:0]            fn;
    logic [OUT_W-1:0]            fp;
    logic [OUT_W-1:0]            tn;
  } tok_t;

endpackage

// File: hw/rtl/roccb_cell.sv
// One threshold cell: four saturating counters and a token stage.
module roccb_cell #(
  parameter int K       = 0,
  parameter int COUNT_W = roccb_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  roccb_pkg::tok_t  tok_i,
  output roccb_pkg::tok_t  tok_o
);

  roccb_pkg::tok_t      tok_r, tok_nxt;
  logic [COUNT_W-1:0]   tp_r, fn_r, fp_r, tn_r;
  logic [COUNT_W-1:0]   tp_nxt, fn_nxt, fp_nxt, tn_nxt;
  logic [roccb_pkg::STEP_W:0] sum;
  logic signed [roccb_pkg::STEP_W:0] thr_s, score_s;
  logic                 active, marked, hit, is_pix;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    sat_inc = (&c) ? c : c + COUNT_W'(1);
  endfunction

  function automatic logic [roccb_pkg::OUT_W-1:0] clip(input logic [COUNT_W-1:0] c);
    clip = (64'(c) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(c);
  endfunction

  always_comb begin
    tok_nxt = tok_i;
    tp_nxt  = tp_r;
    fn_nxt  = fn_r;
    fp_nxt  = fp_r;
    tn_nxt  = tn_r;

    sum     = {1'b0, tok_i.thr} + {1'b0, tok_i.step};
    thr_s   = $signed({1'b0, tok_i.thr});
    score_s = $signed({tok_i.score[roccb_pkg::SCORE_W-1], tok_i.score});
    active  = 32'(tok_i.count) > 32'(K);
    marked  = tok_i.big || (score_s < thr_s);
    hit     = 32'(tok_i.idx) == 32'(K);
    is_pix  = tok_i.vld && (tok_i.op == roccb_pkg::CMD_PIXEL) && active;

    tok_nxt.thr = sum[roccb_pkg::STEP_W-1:0];
    tok_nxt.big = tok_i.big | sum[roccb_pkg::STEP_W];

    if (is_pix) begin
      if (tok_i.changed && marked)        tp_nxt = sat_inc(tp_r);
      else if (tok_i.changed)             fn_nxt = sat_inc(fn_r);
      else if (marked)                    fp_nxt = sat_inc(fp_r);
      else                                tn_nxt = sat_inc(tn_r);
    end

    if (tok_i.vld && (tok_i.op == roccb_pkg::CMD_READ) && hit) begin
      tok_nxt.tp = clip(tp_r);
      tok_nxt.fn = clip(fn_r);
      tok_nxt.fp = clip(fp_r);
      tok_nxt.tn = clip(tn_r);
    end

    if (tok_i.vld && (tok_i.op == roccb_pkg::CMD_CLEAR)) begin
      tp_nxt = '0;
      fn_nxt = '0;
      fp_nxt = '0;
      tn_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
      tp_r      <= '0;
      fn_r      <= '0;
      fp_r      <= '0;
      tn_r      <= '0;
    end else if (adv) begin
      tok_r <= tok_nxt;
      tp_r  <= tp_nxt;
      fn_r  <= fn_nxt;
      fp_r  <= fp_nxt;
      tn_r  <= tn_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// File: hw/rtl/roc_confusion_counter_bank.sv
// Top level of the ROC confusion counter bank: input beat decode, cell chain, output register.
//
// The bank is a row of MAX_THRESHOLDS cells, one per threshold, each holding
// its own four saturating counters (TP, FN, FP, TN). Every accepted beat
// becomes a token that walks the row one cell per cycle while the row moves;
// cell k sees threshold k*step (built by adding the step as the token moves)
// and counts a pixel when k < threshold_count. Step and count are sampled into
// the token when the beat is accepted. A read token picks up the counters of
// the cell whose number matches its index and, after the last cell, is loaded
// into the output register, where the read result then shows as valid. A
// clear token zeroes each cell as it passes, so beats keep their order against
// it. Pixels, clears and ignored beats (truth other than 0 or 255, unused
// command) never stall the row; one beat per cycle is sustained while it moves.
// The whole row holds only while a read result sits at the end of the row and
// the output register is full and not being taken. Reset clears all counters
// at once; no clearing pass.
module roc_confusion_counter_bank #(
  parameter int MAX_THRESHOLDS = roccb_pkg::MAX_THRESHOLDS_DEF,
  parameter int COUNT_WIDTH    = roccb_pkg::COUNT_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // input beats
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // cmd[1:0], score[17:2], truth[25:18], index[32:26], zero pad
  // result beats
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // read_index[6:0], true_positive[38:7],
                                   // false_negative[70:39], false_positive[102:71],
                                   // true_negative[134:103], zero pad
  // configuration writes
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [15:0]  cfg_wdata
);

  roccb_pkg::tok_t chain [MAX_THRESHOLDS+1];
  roccb_pkg::tok_t tok_in, last;

  logic [roccb_pkg::STEP_W-1:0]    step_r;
  logic [roccb_pkg::CNT_CFG_W-1:0] count_r;

  logic                            out_valid_r, out_valid_nxt;
  logic [135:0]                    out_data_r, out_data_nxt;
  logic                            adv, last_read;

  roccb_pkg::cmd_t                 in_cmd;
  logic [roccb_pkg::TRUTH_W-1:0]   in_truth;
  logic                            truth_ok;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= roccb_pkg::STEP_W'(roccb_pkg::STEP_RESET);
      count_r <= roccb_pkg::CNT_CFG_W'(roccb_pkg::COUNT_RESET);
    end else if (cfg_we) begin
      unique case (roccb_pkg::reg_idx_t'(cfg_addr))
        roccb_pkg::REG_STEP:  step_r  <= cfg_wdata;
        roccb_pkg::REG_COUNT: count_r <= cfg_wdata[roccb_pkg::CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Row moves unless a read result would be blocked at its end
  assign last      = chain[MAX_THRESHOLDS];
  assign last_read = last.vld && (last.op == roccb_pkg::CMD_READ);
  assign adv       = !out_valid_r || out_tready || !last_read;
  assign in_tready = adv;

  // Input beat to token
  assign in_cmd   = roccb_pkg::cmd_t'(in_tdata[1:0]);
  assign in_truth = in_tdata[25:18];
  assign truth_ok = (in_truth == roccb_pkg::TRUTH_CHANGED) ||
                    (in_truth == roccb_pkg::TRUTH_UNCHANGED);

  always_comb begin
    tok_in         = '0;
    tok_in.op      = in_cmd;
    tok_in.score   = $signed(in_tdata[17:2]);
    tok_in.changed = (in_truth == roccb_pkg::TRUTH_CHANGED);
    tok_in.step    = step_r;
    tok_in.count   = count_r;
    tok_in.idx     = in_tdata[32:26];
    unique case (in_cmd) inside
      roccb_pkg::CMD_PIXEL: tok_in.vld = in_tvalid && truth_ok;
      roccb_pkg::CMD_READ,
      roccb_pkg::CMD_CLEAR: tok_in.vld = in_tvalid;
      default:              tok_in.vld = 1'b0;
    endcase
  end

  assign chain[0] = tok_in;

  for (genvar k = 0; k < MAX_THRESHOLDS; k++) begin : g_cell
    roccb_cell #(
      .K       (k),
      .COUNT_W (COUNT_WIDTH)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (chain[k]),
      .tok_o (chain[k+1])
    );
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (adv && last_read) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, last.tn, last.fp, last.fn, last.tp, last.idx};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");

  a_read_lands : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last_read) |=> out_tvalid)
    else $error("read token left the row without a result");

  a_hold_on_block : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready && last_read) |-> !in_tready)
    else $error("row advanced over a blocked read result");

endmodule

// File: sim/roccb_checker.sv
// Checker for the ROC confusion counter bank: tracks the counters, predicts read beats, compares.
module roccb_checker
  import roccb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [39:0]  in_tdata,   // cmd[1:0], score[17:2], truth[25:18], index[32:26]
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [135:0] out_tdata,  // read_index[6:0], tp[38:7], fn[70:39], fp[102:71], tn[134:103]
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [15:0]  cfg_wdata,
  output int           fail_count,
  output int           reads_waiting
);

  localparam int NCELL = MAX_THRESHOLDS_DEF;
  localparam int CW    = COUNT_WIDTH_DEF;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [OUT_W-1:0]   tp;
    logic [OUT_W-1:0]   fn;
    logic [OUT_W-1:0]   fp;
    logic [OUT_W-1:0]   tn;
  } readout_t;

  logic [STEP_W-1:0]    step_q;
  logic [CNT_CFG_W-1:0] count_q;
  logic [CW-1:0]        tp_cnt [NCELL];
  logic [CW-1:0]        fn_cnt [NCELL];
  logic [CW-1:0]        fp_cnt [NCELL];
  logic [CW-1:0]        tn_cnt [NCELL];
  readout_t             readout_q [$];

  initial begin
    fail_count    = 0;
    reads_waiting = 0;
  end

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
    return (&c) ? c : c + 1'b1;  // counters stick at full scale
  endfunction

  task automatic wipe_counts();
    for (int k = 0; k < NCELL; k++) begin
      tp_cnt[k] = '0;
      fn_cnt[k] = '0;
      fp_cnt[k] = '0;
      tn_cnt[k] = '0;
    end
  endtask

  // One pixel walks every active threshold; marked changed when score < k*step.
  task automatic count_pixel(input logic signed [SCORE_W-1:0] score, input logic changed);
    int     n;
    longint thr;
    bit     marked;
    n = (count_q > NCELL) ? NCELL : int'(count_q);
    for (int k = 0; k < n; k++) begin
      thr    = longint'(k) * longint'(step_q);
      marked = longint'(score) < thr;
      if (changed) begin
        if (marked) tp_cnt[k] = bump(tp_cnt[k]);
        else        fn_cnt[k] = bump(fn_cnt[k]);
      end else begin
        if (marked) fp_cnt[k] = bump(fp_cnt[k]);
        else        tn_cnt[k] = bump(tn_cnt[k]);
      end
    end
  endtask

  task automatic take_beat(input logic [39:0] beat);
    cmd_t                      op;
    logic signed [SCORE_W-1:0] score;
    logic [TRUTH_W-1:0]        truth;
    logic [INDEX_W-1:0]        idx;
    readout_t                  r;
    op    = cmd_t'(beat[1:0]);
    score = beat[17:2];
    truth = beat[25:18];
    idx   = beat[32:26];
    case (op)
      CMD_PIXEL: begin
        if (truth == TRUTH_CHANGED || truth == TRUTH_UNCHANGED)
          count_pixel(score, truth == TRUTH_CHANGED);
      end
      CMD_READ: begin
        r = '0;
        r.idx = idx;
        if (idx < NCELL) begin
          r.tp = tp_cnt[idx];
          r.fn = fn_cnt[idx];
          r.fp = fp_cnt[idx];
          r.tn = tn_cnt[idx];
        end
        readout_q = {readout_q, r};
      end
      CMD_CLEAR: wipe_counts();
      default: ;  // unused command: nothing happens
    endcase
  endtask

  task automatic check_readout(input logic [135:0] beat);
    readout_t got;
    readout_t want;
    string    exp_s;
    string    got_s;
    got.idx = beat[6:0];
    got.tp  = beat[38:7];
    got.fn  = beat[70:39];
    got.fp  = beat[102:71];
    got.tn  = beat[134:103];
    if (readout_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected read beat idx=%0d tp=%0d fn=%0d fp=%0d tn=%0d",
                 $realtime, got.idx, got.tp, got.fn, got.fp, got.tn);
    end else begin
      want = readout_q.pop_front();
      if (got != want) begin
        fail_count++;
        if (fail_count <= 10) begin
          exp_s = $sformatf("idx=%0d tp=%0d fn=%0d fp=%0d tn=%0d",
                            want.idx, want.tp, want.fn, want.fp, want.tn);
          got_s = $sformatf("idx=%0d tp=%0d fn=%0d fp=%0d tn=%0d",
                            got.idx, got.tp, got.fn, got.fp, got.tn);
          $display("%0t: read mismatch exp %s | got %s", $realtime, exp_s, got_s);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      step_q  = STEP_W'(STEP_RESET);
      count_q = CNT_CFG_W'(COUNT_RESET);
      wipe_counts();
      readout_q.delete();
    end else begin
      if (cfg_we) begin
        if (reg_idx_t'(cfg_addr) == REG_STEP) step_q = cfg_wdata;
        else                                  count_q = cfg_wdata[CNT_CFG_W-1:0];
      end
      if (out_tvalid && out_tready) check_readout(out_tdata);
      if (in_tvalid && in_tready) take_beat(in_tdata);
    end
    reads_waiting = readout_q.size();
  end

endmodule

// File: sim/tb_top.sv
// Testbench top for the ROC confusion counter bank: clock, reset, stimulus and verdict.
module tb_top;
  import roccb_pkg::*;

  // A read result is valid once its token has crossed the row into the output register;
  // pixels and clears give no beat but still walk the whole row.
  localparam int SETTLE   = MAX_THRESHOLDS_DEF + 8;
  // Worst quiet stretch: settle pause plus a read crossing the row plus stalls.
  localparam int WATCHDOG = 2000;
  localparam int NPHASE   = 7;
  localparam int PHASE_N  = 120;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [39:0]  in_tdata;   // cmd[1:0], score[17:2], truth[25:18], index[32:26], zero pad
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;  // read_index[6:0], true_positive[38:7], false_negative[70:39],
                            // false_positive[102:71], true_negative[134:103], zero pad
  logic         cfg_we;
  logic         cfg_addr;
  logic [15:0]  cfg_wdata;

  int           fail_count;
  int           reads_waiting;

  // Threshold settings as last written, used to aim scores at thresholds.
  int           cur_step;
  int           cur_count;
  // Per-phase switches: calm side never idles.
  bit           tx_calm;
  bit           rx_calm;

  roc_confusion_counter_bank u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  roccb_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .reads_waiting (reads_waiting)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Result side: after each taken beat, hold tready low for rx_hold, a random draw per beat (zero in calm phases).
  // ---------------------------------------------------------------------------
  logic out_taken;
  int   rx_hold;

  initial begin
    out_taken  = 1'b0;
    out_tready = 1'b0;
    rx_hold    = 0;
  end

  always @(posedge clk) out_taken <= out_tvalid && out_tready;

  always @(negedge clk) begin
    if (out_taken) rx_hold = rx_calm ? 0 : $urandom_range(0, 19);
    if (rx_hold != 0) begin
      out_tready <= 1'b0;
      rx_hold--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any beat or register write means a hang.
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles;
  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("[roc_confusion_counter_bank] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Drive one beat and return once it is taken. tvalid is only lowered when a
  // gap follows, so back-to-back beats never drop it.
  task automatic send_beat(input cmd_t op, input logic [15:0] score,
                           input logic [7:0] truth, input logic [6:0] idx);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, idx, truth, score, op};
    do @(posedge clk); while (!in_tready);
  endtask

  // Wait until every read came back, then let pixels and clears leave the row.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (reads_waiting != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Both registers; junk in the upper bits of the count write must be dropped.
  task automatic set_thresholds(input int step, input int count);
    logic [7:0] junk;
    junk = $urandom_range(0, 255);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_STEP;
    cfg_wdata <= step[15:0];
    @(negedge clk);
    cfg_addr  <= REG_COUNT;
    cfg_wdata <= {junk, count[7:0]};
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_step  = step;
    cur_count = count;
  endtask

  // Most scores land on or next to a threshold so the compare edge gets hit.
  function automatic logic [15:0] pick_score();
    int n;
    int s;
    n = (cur_count > MAX_THRESHOLDS_DEF) ? MAX_THRESHOLDS_DEF : cur_count;
    if (n == 0 || $urandom_range(0, 9) < 4) return 16'($urandom);
    s = int'($urandom_range(0, n - 1)) * cur_step + int'($urandom_range(0, 2)) - 1;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return s[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          steps  [NPHASE];
    int          counts [NPHASE];
    int unsigned r;
    logic [7:0]  t;

    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_STEP;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    tx_calm   = 1'b0;
    rx_calm   = 1'b0;
    cur_step  = STEP_RESET;
    cur_count = COUNT_RESET;

    // Step/count per phase: bank extremes, zero and oversize count, tiny and
    // huge spacing (huge marks every pixel changed above threshold zero).
    steps  = '{0, 65535, 1, 205, 1000, 0, 37};
    counts = '{1, 128, 255, 0, 50, 128, 101};
    steps[5] = $urandom_range(2, 400);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings (step 205, 101 thresholds).
    send_beat(CMD_READ,  16'h0000, 8'd0,   7'd0);      // fresh counters are zero
    send_beat(CMD_PIXEL, 16'h0000, 8'd255, 7'd127);    // score equal to threshold 0
    send_beat(CMD_PIXEL, 16'h8000, 8'd255, 7'd0);      // most negative score
    send_beat(CMD_PIXEL, 16'h7FFF, 8'd0,   7'd85);     // most positive score
    send_beat(CMD_PIXEL, 16'hFFFF, 8'd0,   7'd42);     // just below zero
    send_beat(CMD_PIXEL, 16'd205,  8'd0,   7'd1);      // exactly on threshold 1
    send_beat(CMD_PIXEL, 16'd204,  8'd255, 7'd1);      // just under threshold 1
    send_beat(CMD_PIXEL, 16'd100,  8'd1,   7'd0);      // ignored truth values
    send_beat(CMD_PIXEL, 16'd100,  8'd254, 7'd0);
    send_beat(CMD_PIXEL, 16'd100,  8'd128, 7'd0);
    send_beat(CMD_NONE,  16'hFFFF, 8'd255, 7'd127);    // unused command
    send_beat(CMD_READ,  16'hFFFF, 8'd255, 7'd0);
    send_beat(CMD_READ,  16'h0000, 8'd0,   7'd1);
    send_beat(CMD_READ,  16'h0000, 8'd0,   7'd100);    // last active threshold
    send_beat(CMD_READ,  16'h0000, 8'd0,   7'd101);    // beyond count: untouched
    send_beat(CMD_READ,  16'h0000, 8'd0,   7'd127);
    send_beat(CMD_CLEAR, 16'hA5A5, 8'd255, 7'd127);
    send_beat(CMD_READ,  16'h0000, 8'd0,   7'd1);      // zero after clear
    send_beat(CMD_PIXEL, 16'hFC00, 8'd255, 7'd3);      // score -1024 counts at every threshold
    send_beat(CMD_READ,  16'h0000, 8'd0,   7'd0);
    send_beat(CMD_READ,  16'h0000, 8'd0,   7'd100);

    // Pause until every read is back before touching the registers.
    drain();

    // Random phases; each starts idle with a new threshold setting. Counters
    // carry over, so a small count shows what a larger one left behind.
    for (int p = 0; p < NPHASE; p++) begin
      set_thresholds(steps[p], counts[p]);
      tx_calm = p[0];
      rx_calm = p[1];
      for (int i = 0; i < PHASE_N; i++) begin
        r = $urandom_range(0, 99);
        if (r < 64) begin
          t = $urandom_range(0, 1) ? TRUTH_CHANGED : TRUTH_UNCHANGED;
          send_beat(CMD_PIXEL, pick_score(), t, 7'($urandom));
        end else if (r < 71) begin
          send_beat(CMD_PIXEL, 16'($urandom), 8'($urandom), 7'($urandom));
        end else if (r < 74) begin
          send_beat(CMD_PIXEL, $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF,
                    $urandom_range(0, 1) ? TRUTH_CHANGED : TRUTH_UNCHANGED, 7'($urandom));
        end else if (r < 94) begin
          send_beat(CMD_READ, 16'($urandom), 8'($urandom), 7'($urandom));
        end else if (r < 96) begin
          send_beat(CMD_CLEAR, 16'($urandom), 8'($urandom), 7'($urandom));
        end else begin
          send_beat(CMD_NONE, 16'($urandom), 8'($urandom), 7'($urandom));
        end
      end
      drain();
    end

    if (fail_count == 0 && reads_waiting == 0) begin
      $display("[roc_confusion_counter_bank] OK");
    end else begin
      $display("[roc_confusion_counter_bank] ERROR");
    end
    $finish;
  end

endmodule
